/* rtl/rfwa_pkg.sv */
// rfwa_pkg: shared types and constants for the range-fit weighted arg-max block.
// Used by the top level and the iterative divider.
`default_nettype none

package rfwa_pkg;

  localparam int COORD_W  = 16;  // signed Q8.8 climate values and bounds
  localparam int BASE_W   = 16;  // unsigned Q8.8 base weight
  localparam int FRAC_W   = 16;  // margin fraction, unsigned Q0.16
  localparam int MINM_W   = 15;  // min margin, unsigned Q7.8
  localparam int INDEX_W  = 8;
  localparam int WEIGHT_W = 24;  // unsigned Q8.16

  // config register indexes
  localparam logic REG_MARGIN_FRACTION = 1'b0;
  localparam logic REG_MIN_MARGIN      = 1'b1;

  localparam logic [FRAC_W-1:0] MARGIN_FRACTION_RST = 16'd16384;
  localparam logic [MINM_W-1:0] MIN_MARGIN_RST      = 15'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARGIN,
    ST_FIT,
    ST_DIV,
    ST_MUL_T,
    ST_MUL_W,
    ST_SCORE,
    ST_EMIT
  } rfwa_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rfwa_div_stat_t;

endpackage

`default_nettype wire

/* rtl/rfwa_mul.sv */
// rfwa_mul: shared unsigned multiplier with registered product.
// Depends on nothing but its parameters.
`default_nettype none

module rfwa_mul #(
  parameter int AW = 16,
  parameter int BW = 17
) (
  input  wire logic            clk,
  input  wire logic [AW-1:0]   a,
  input  wire logic [BW-1:0]   b,
  output logic [AW+BW-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

`default_nettype wire

/* rtl/rfwa_div.sv */
// rfwa_div: radix-2 restoring divider for fractions, num < den.
// Produces FB quotient bits of num * 2^FB / den, one bit per cycle. Uses rfwa_pkg.
`default_nettype none

module rfwa_div #(
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [15:0]          num,
  input  wire logic [15:0]          den,
  output rfwa_pkg::rfwa_div_stat_t  stat,
  output logic [FB-1:0]             quot_r
);
  import rfwa_pkg::*;

  localparam int CNT_W = $clog2(FB + 1);

  logic [15:0]      rem_r;
  logic [15:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [16:0]      shifted;
  logic             ge;
  logic [16:0]      diff;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[15:0] : shifted[15:0];
      quot_r <= {quot_r[FB-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* rtl/range_fit_weighted_argmax.sv */
// range_fit_weighted_argmax: weighted arg-max over a scan of candidate ranges.
// Top level; uses rfwa_pkg, rfwa_mul and rfwa_div.
//
//  Channel | Dir | Signals                              | Carries
//  --------+-----+--------------------------------------+---------------------------------
//  in_     | in  | tvalid/tready/tdata[111:0]/tlast     | one candidate per transfer
//  out_    | out | tvalid/tready/tdata[31:0]/tuser      | scan result on the last candidate
//  cfg_    | in  | APB psel/penable/pwrite/paddr/pwdata | margin_fraction @0, min_margin @4
//
// Steps: a candidate is taken in ST_IDLE, then each axis passes ST_MARGIN and ST_FIT,
//   with ST_DIV only when its value lies outside the range but inside the margin;
//   then ST_MUL_T, ST_MUL_W and ST_SCORE, and a last candidate adds ST_EMIT. The
//   radix-2 divider gives one quotient bit a cycle; one multiplier serves margin
//   and weight products.
// Candidates past MAX_CANDIDATES skip scoring; a last one goes straight to ST_EMIT.
// Reset: synchronous, active low; clears scan state and output valid, loads
//   the register reset values.
// Stalls: in_tready is high only while idle. A finished result sits in the
//   output register; a following last candidate waits in ST_EMIT until it drains.
`default_nettype none

module range_fit_weighted_argmax #(
  parameter int MAX_CANDIDATES = 256,
  parameter int FIT_BITS       = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // candidate stream
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // low to high: temperature, moisture, min_temperature, max_temperature,
  //   min_moisture, max_moisture, base_weight (16 bits each)
  input  wire logic [111:0]  in_tdata,
  input  wire logic          in_tlast,
  // result stream
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // low to high: best_index[7:0], best_weight[31:8]
  output logic [31:0]        out_tdata,
  // bit 0: found
  output logic [0:0]         out_tuser,
  // configuration
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import rfwa_pkg::*;

  localparam int FB   = FIT_BITS;
  localparam int CW   = $clog2(MAX_CANDIDATES + 1);
  localparam int IW   = (CW < INDEX_W) ? CW : INDEX_W;
  localparam int BW   = (FB + 1 > FRAC_W) ? FB + 1 : FRAC_W;
  localparam int PW   = BASE_W + BW;
  localparam logic [FB:0] FIT_ONE = {1'b1, {FB{1'b0}}};

  // ---------------- configuration registers ----------------
  logic [FRAC_W-1:0] margin_fraction_r;
  logic [MINM_W-1:0] min_margin_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_fraction_r <= MARGIN_FRACTION_RST;
      min_margin_r      <= MIN_MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MARGIN_FRACTION: margin_fraction_r <= cfg_pwdata[FRAC_W-1:0];
        REG_MIN_MARGIN:      min_margin_r      <= cfg_pwdata[MINM_W-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MARGIN_FRACTION: cfg_prdata = 32'(margin_fraction_r);
      REG_MIN_MARGIN:      cfg_prdata = 32'(min_margin_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- captured candidate ----------------
  logic signed [COORD_W-1:0] temperature_r, moisture_r;
  logic signed [COORD_W-1:0] min_temperature_r, max_temperature_r;
  logic signed [COORD_W-1:0] min_moisture_r, max_moisture_r;
  logic [BASE_W-1:0]         base_weight_r;
  logic                      last_r;
  logic                      in_xfer;

  assign in_xfer = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      temperature_r     <= in_tdata[15:0];
      moisture_r        <= in_tdata[31:16];
      min_temperature_r <= in_tdata[47:32];
      max_temperature_r <= in_tdata[63:48];
      min_moisture_r    <= in_tdata[79:64];
      max_moisture_r    <= in_tdata[95:80];
      base_weight_r     <= in_tdata[111:96];
      last_r            <= in_tlast;
    end
  end

  // ---------------- sequencer state ----------------
  rfwa_state_t       state_r, state_nxt;
  logic              axis_r, axis_nxt;          // 0 = temperature, 1 = moisture
  logic [FB:0]       tfit_r, tfit_nxt;
  logic [FB:0]       mfit_r, mfit_nxt;
  logic [WEIGHT_W-1:0] best_weight_r, best_weight_nxt;
  logic [INDEX_W-1:0]  best_index_r, best_index_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_found_r, out_found_nxt;

  // ---------------- axis evaluation ----------------
  logic signed [COORD_W-1:0] val, lo, hi;
  logic signed [COORD_W:0]   span, dist_lo, dist_hi;
  logic                      in_range, below;
  logic [15:0]               width, offset, margin_raw, minm, margin;

  // shared units
  logic [BASE_W-1:0] mul_a;
  logic [BW-1:0]     mul_b;
  logic [PW-1:0]     prod_r;
  logic              div_start;
  rfwa_div_stat_t    div_stat;
  logic [FB-1:0]     quot;

  logic [WEIGHT_W-1:0] weight;
  logic                score_en;
  logic                fit_wr;
  logic [FB:0]         fit_val;
  logic                out_free;

  always_comb begin
    val = axis_r ? moisture_r     : temperature_r;
    lo  = axis_r ? min_moisture_r : min_temperature_r;
    hi  = axis_r ? max_moisture_r : max_temperature_r;

    in_range = (val >= lo) && (val <= hi);
    below    = val < lo;
    span     = $signed({hi[COORD_W-1], hi}) - $signed({lo[COORD_W-1], lo});
    dist_lo  = $signed({lo[COORD_W-1], lo}) - $signed({val[COORD_W-1], val});
    dist_hi  = $signed({val[COORD_W-1], val}) - $signed({hi[COORD_W-1], hi});
    // inverted or empty ranges have zero width
    width    = (!span[COORD_W] && (span != '0)) ? span[15:0] : '0;
    offset   = below ? dist_lo[15:0] : dist_hi[15:0];

    margin_raw = prod_r[FRAC_W +: 16];
    minm       = (min_margin_r == '0) ? 16'd1 : {1'b0, min_margin_r};
    margin     = (margin_raw < minm) ? minm : margin_raw;

    weight   = prod_r[FB-8 +: WEIGHT_W];
    score_en = cnt_r < CW'(MAX_CANDIDATES);
    out_free = !out_valid_r || out_tready;
  end

  rfwa_mul #(.AW(BASE_W), .BW(BW)) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  rfwa_div #(.FB(FB)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (offset),
    .den    (margin),
    .stat   (div_stat),
    .quot_r (quot)
  );

  // ---------------- next state and datapath control ----------------
  always_comb begin
    state_nxt       = state_r;
    axis_nxt        = axis_r;
    tfit_nxt        = tfit_r;
    mfit_nxt        = mfit_r;
    best_weight_nxt = best_weight_r;
    best_index_nxt  = best_index_r;
    found_nxt       = found_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_data_nxt    = out_data_r;
    out_found_nxt   = out_found_r;
    in_tready       = 1'b0;
    div_start       = 1'b0;
    fit_wr          = 1'b0;
    fit_val         = '0;
    mul_a           = width;
    mul_b           = BW'(margin_fraction_r);

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        axis_nxt  = 1'b0;
        if (in_tvalid) begin
          if (score_en)      state_nxt = ST_MARGIN;
          else if (in_tlast) state_nxt = ST_EMIT;
        end
      end
      ST_MARGIN: begin
        // margin product: width * fraction, Q0.16 drop
        state_nxt = ST_FIT;
      end
      ST_FIT: begin
        if (in_range) begin
          fit_wr  = 1'b1;
          fit_val = FIT_ONE;
        end else if (offset >= margin) begin
          fit_wr  = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          fit_wr  = 1'b1;
          fit_val = FIT_ONE - {1'b0, quot};
        end
      end
      ST_MUL_T: begin
        mul_a     = base_weight_r;
        mul_b     = BW'(tfit_r);
        state_nxt = ST_MUL_W;
      end
      ST_MUL_W: begin
        // t = base * tfit >> FB, Q8.8
        mul_a     = prod_r[FB +: BASE_W];
        mul_b     = BW'(mfit_r);
        state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        if (weight > best_weight_r) begin
          best_weight_nxt = weight;
          best_index_nxt  = INDEX_W'(cnt_r[IW-1:0]);
          found_nxt       = 1'b1;
        end
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_data_nxt    = {best_weight_r, best_index_r};
          out_found_nxt   = found_r;
          best_weight_nxt = '0;
          best_index_nxt  = '0;
          found_nxt       = 1'b0;
          cnt_nxt         = '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // fit done for the current axis: store it and move on
    if (fit_wr) begin
      if (axis_r) begin
        mfit_nxt  = fit_val;
        state_nxt = ST_MUL_T;
      end else begin
        tfit_nxt  = fit_val;
        axis_nxt  = 1'b1;
        state_nxt = ST_MARGIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      axis_r        <= 1'b0;
      best_weight_r <= '0;
      best_index_r  <= '0;
      found_r       <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      axis_r        <= axis_nxt;
      best_weight_r <= best_weight_nxt;
      best_index_r  <= best_index_nxt;
      found_r       <= found_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tfit_r      <= tfit_nxt;
    mfit_r      <= mfit_nxt;
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_found_r;

endmodule

`default_nettype wire

/* rtl/rfwa_checker.sv */
// rfwa_checker: port-level assertions for range_fit_weighted_argmax, plus bind.
// Sees only the top-level ports.
`default_nettype none

module rfwa_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tlast,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [31:0]  out_tdata,
  input wire logic [0:0]   out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no winner: index and weight are zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0)
    else $error("nonzero result without a winner");

  // a winner always has a positive weight
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[31:8] != 24'd0)
    else $error("winner with zero weight");

  // a last candidate always keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("accepted a candidate right after a last one");

endmodule

bind range_fit_weighted_argmax rfwa_checker u_rfwa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* tb/sv/range_fit_argmax_checker.sv */
// range_fit_argmax_checker: passive monitor for range_fit_weighted_argmax. It tracks the
// register port, scores candidates within the scan limit and compares every scan result.
// Depends on rfwa_pkg for register indexes, reset values and field widths.
`timescale 1ns / 1ps

module range_fit_argmax_checker #(
  parameter int SCAN_LIMIT = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // low to high: temperature, moisture, min_temperature, max_temperature,
  //   min_moisture, max_moisture, base_weight
  input  wire logic [111:0] in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // low to high: best_index, best_weight
  input  wire logic [31:0]  out_tdata,
  // bit 0: found
  input  wire logic [0:0]   out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  input  wire logic [31:0]  cfg_prdata,
  input  wire logic         cfg_pready,
  output int                mismatches,
  output int                results_due
);

  typedef struct packed {
    logic                            found;
    logic [rfwa_pkg::INDEX_W-1:0]    winner;
    logic [rfwa_pkg::WEIGHT_W-1:0]   weight;
  } scan_result_t;

  scan_result_t expected_results[$];

  logic [rfwa_pkg::FRAC_W-1:0]   margin_fraction;
  logic [rfwa_pkg::MINM_W-1:0]   min_margin;
  logic [rfwa_pkg::WEIGHT_W-1:0] run_weight;
  logic [rfwa_pkg::INDEX_W-1:0]  run_winner;
  logic                          run_found;
  int                            scan_pos;

  // Fit of one axis in 0 .. 2^16; 2^16 means inside the closed range.
  function automatic longint axis_fit(input longint v, input longint lo, input longint hi);
    longint width, margin, floor_m, offset;
    if (v >= lo && v <= hi) return 64'sd65536;
    width   = (hi > lo) ? hi - lo : 0;
    margin  = (width * longint'(margin_fraction)) >>> 16;
    floor_m = (min_margin == '0) ? 1 : longint'(min_margin);
    if (margin < floor_m) margin = floor_m;
    // inverted range: below min measures from min, anything else from max
    offset = (v < lo) ? lo - v : v - hi;
    if (offset >= margin) return 0;
    return 65536 - (offset * 65536) / margin;
  endfunction

  function automatic logic [rfwa_pkg::WEIGHT_W-1:0] candidate_weight(input logic [111:0] d);
    longint tfit, mfit, scaled;
    tfit   = axis_fit($signed(d[15:0]), $signed(d[47:32]), $signed(d[63:48]));
    mfit   = axis_fit($signed(d[31:16]), $signed(d[79:64]), $signed(d[95:80]));
    scaled = (longint'(d[111:96]) * tfit) >>> 16;        // Q8.8
    return 24'((scaled * mfit) >>> 8);                   // Q8.16
  endfunction

  always @(posedge clk) begin : monitor
    logic [rfwa_pkg::WEIGHT_W-1:0] w;
    logic [31:0]                   reg_value;
    scan_result_t                  want;
    if (!rst_n) begin
      margin_fraction = rfwa_pkg::MARGIN_FRACTION_RST;
      min_margin      = rfwa_pkg::MIN_MARGIN_RST;
      run_weight      = '0;
      run_winner      = '0;
      run_found       = 1'b0;
      scan_pos        = 0;
      expected_results.delete();
      mismatches      = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == rfwa_pkg::REG_MIN_MARGIN) min_margin = cfg_pwdata[14:0];
          else margin_fraction = cfg_pwdata[15:0];
        end else begin
          reg_value = (cfg_paddr[2] == rfwa_pkg::REG_MIN_MARGIN) ? 32'(min_margin)
                                                                 : 32'(margin_fraction);
          if (cfg_prdata !== reg_value) begin
            mismatches++;
            $display("%0t: register read at %0d, expected %0d actual %0d",
                     $time, cfg_paddr, reg_value, cfg_prdata);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        // past the scan limit a candidate is neither scored nor counted
        if (scan_pos < SCAN_LIMIT) begin
          w = candidate_weight(in_tdata);
          if (w > run_weight) begin
            run_weight = w;
            run_winner = 8'(scan_pos);
            run_found  = 1'b1;
          end
          scan_pos++;
        end
        if (in_tlast) begin
          want.found  = run_found;
          want.winner = run_found ? run_winner : '0;
          want.weight = run_found ? run_weight : '0;
          expected_results.push_back(want);
          run_weight = '0;
          run_winner = '0;
          run_found  = 1'b0;
          scan_pos   = 0;
        end
      end

      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual found=%0d index=%0d weight=%0d",
                   $time, out_tuser[0], out_tdata[7:0], out_tdata[31:8]);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[0] !== want.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, want.found, out_tuser[0]);
          end
          if (out_tdata[7:0] !== want.winner) begin
            mismatches++;
            $display("%0t: best_index mismatch, expected %0d actual %0d",
                     $time, want.winner, out_tdata[7:0]);
          end
          if (out_tdata[31:8] !== want.weight) begin
            mismatches++;
            $display("%0t: best_weight mismatch, expected %0d actual %0d",
                     $time, want.weight, out_tdata[31:8]);
          end
        end
      end
    end
    results_due = expected_results.size();
  end

endmodule

/* tb/sv/range_fit_weighted_argmax_test.sv */
// range_fit_weighted_argmax_test: top of the range_fit_weighted_argmax testbench.
// Drives candidates, register writes and result backpressure; the verdict comes
// from range_fit_argmax_checker. Depends on rfwa_pkg and the block itself.
`timescale 1ns / 1ps

module range_fit_weighted_argmax_test;

  localparam int SCAN_LIMIT    = 256;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int PHASE_ITEMS   = 250;   // candidates between register updates
  localparam int LONG_SCAN     = 280;   // runs past the scan limit
  localparam int SETTLE_CYCLES = 64;    // longer than the slowest candidate

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // low to high: temperature, moisture, min_temperature, max_temperature,
  //   min_moisture, max_moisture, base_weight (16 bits each)
  logic [111:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  // low to high: best_index[7:0], best_weight[31:8]
  logic [31:0]  out_tdata;
  // bit 0: found
  logic [0:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int mismatches;
  int results_due;
  int sent;        // candidates handed over in the random part
  bit calm;        // phase with no idling on either side

  range_fit_weighted_argmax #(
    .MAX_CANDIDATES(SCAN_LIMIT),
    .FIT_BITS      (16)
  ) u_dut (.*);

  range_fit_argmax_checker #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~3 ms).
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Idle/stall lengths: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int jitter(input int c, input int spread);
    return clamp16(c + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic int scan_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(31, 80);
  endfunction

  // Result side backpressure, changed at falling edges only.
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 99) < 65) begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b0;
        hold = gap_len();
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  // One candidate transfer. tvalid stays high from one candidate to the next
  // unless a gap is drawn; the transfer completes at the rising edge where
  // in_tready is seen high.
  task automatic send_candidate(input int t, m, tlo, thi, mlo, mhi, base, input bit last);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {16'(base), 16'(mhi), 16'(mlo), 16'(thi), 16'(tlo), 16'(m), 16'(t)};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly well-formed candidates: ranges placed around the sample so that
  // inside, falloff and far-off cases all show up. One in ten is pure noise
  // so every bit of every field toggles.
  task automatic send_random_candidate(input bit last);
    int t, m, tlo, thi, mlo, mhi, base, spread;
    if ($urandom_range(0, 9) == 0) begin
      t    = $urandom_range(0, 65535);
      m    = $urandom_range(0, 65535);
      tlo  = $urandom_range(0, 65535);
      thi  = $urandom_range(0, 65535);
      mlo  = $urandom_range(0, 65535);
      mhi  = $urandom_range(0, 65535);
      base = $urandom_range(0, 65535);
    end else begin
      case ($urandom_range(0, 3))
        0:       spread = 16;
        1:       spread = 256;
        2:       spread = 2048;
        default: spread = 16384;
      endcase
      t   = int'($urandom_range(0, 65535)) - 32768;
      m   = int'($urandom_range(0, 65535)) - 32768;
      tlo = jitter(t, spread);
      mlo = jitter(m, spread);
      // occasionally an inverted range
      thi = ($urandom_range(0, 9) == 0) ? jitter(tlo, spread)
                                         : clamp16(tlo + int'($urandom_range(0, spread)));
      mhi = ($urandom_range(0, 9) == 0) ? jitter(mlo, spread)
                                         : clamp16(mlo + int'($urandom_range(0, spread)));
      base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
    end
    send_candidate(t, m, tlo, thi, mlo, mhi, base, last);
  endtask

  task automatic send_scan(input int len);
    for (int k = 0; k < len; k++) send_random_candidate(k == len - 1);
    sent += len;
  endtask

  // Write one register, then read it back (the checker compares prdata).
  task automatic program_register(input logic idx, input int unsigned value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(input int unsigned fraction, input int unsigned floor_margin);
    program_register(rfwa_pkg::REG_MARGIN_FRACTION, fraction);
    program_register(rfwa_pkg::REG_MIN_MARGIN, floor_margin);
  endtask

  // Drop tvalid, let every pending result drain, then give the block time to
  // finish any candidate that produces no result.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase, phase_start;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    sent        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset register values ----
    configure(rfwa_pkg::MARGIN_FRACTION_RST, rfwa_pkg::MIN_MARGIN_RST);
    // lone candidate far outside its margin: nothing found
    send_candidate(0, 0, 1024, 2048, -256, 256, 65535, 1'b1);
    // full-span ranges, largest base, then an equal weight: the first one wins
    send_candidate(-32768, 32767, -32768, 32767, -32768, 32767, 65535, 1'b0);
    send_candidate(32767, -32768, -32768, 32767, -32768, 32767, 65535, 1'b1);
    // falloff below min and above max, inverted ranges, boundaries, far off, zero base
    send_candidate(0, 0, 100, 1124, -10, 10, 256, 1'b0);
    send_candidate(1200, 0, 100, 1124, -10, 10, 256, 1'b0);
    send_candidate(500, 0, 600, 400, -10, 10, 256, 1'b0);
    send_candidate(610, 0, 600, 400, -10, 10, 256, 1'b0);
    send_candidate(100, 10, 100, 1124, -10, 10, 1, 1'b0);
    send_candidate(32767, -32768, -32768, -32768, 32767, 32767, 65535, 1'b0);
    send_candidate(0, 0, -10, 10, -10, 10, 0, 1'b1);
    wait_idle();
    // zero fraction and zero min margin: the floor becomes one
    configure(0, 0);
    send_candidate(10, 0, 11, 20, -5, 5, 65535, 1'b0);
    send_candidate(5, 0, 5, 4, -5, 5, 65535, 1'b0);
    send_candidate(0, 0, 0, 0, 0, 0, 1, 1'b1);
    wait_idle();
    // largest fraction and floor
    configure(65535, 32767);
    send_candidate(-1, 0, -32768, -32767, -32768, 32767, 65535, 1'b0);
    send_candidate(-32768, 32767, 0, 32767, -32768, 0, 65535, 1'b1);

    // ---- random part: phases with different register settings ----
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 6)
        0:       configure($urandom_range(0, 65535), $urandom_range(1, 2048));
        1:       configure(0, 1);
        2:       configure(65535, 32767);
        3:       configure($urandom_range(0, 65535), 0);
        4:       configure(rfwa_pkg::MARGIN_FRACTION_RST, rfwa_pkg::MIN_MARGIN_RST);
        default: configure(65535, 1);
      endcase
      calm = (phase % 4 == 3);
      phase_start = sent;
      if (phase == 1) send_scan(LONG_SCAN);
      while (sent - phase_start < PHASE_ITEMS && sent < RANDOM_ITEMS) send_scan(scan_length());
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    if (mismatches == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* range_fit_weighted_argmax.f */
rtl/rfwa_pkg.sv
rtl/rfwa_mul.sv
rtl/rfwa_div.sv
rtl/range_fit_weighted_argmax.sv
rtl/rfwa_checker.sv
tb/sv/range_fit_argmax_checker.sv
tb/sv/range_fit_weighted_argmax_test.sv
